/* sv/tlb_lru_lookup_insert_unit_macros.svh */
// assertion macros for the translation buffer unit
// expects clk and arst_n in the scope of use
`ifndef TLB_LRU_LOOKUP_INSERT_UNIT_MACROS_SVH
`define TLB_LRU_LOOKUP_INSERT_UNIT_MACROS_SVH

// same-cycle implication, off while in reset
`define TLU_ASSERT_IMPLIES(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("tlu check failed");

// next-cycle implication, off while in reset
`define TLU_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("tlu check failed");

`endif

/* sv/tlu_pkg.sv */
// shared constants, codes and controller/datapath bundles for the tlb unit
// no dependencies
package tlu_pkg;

	localparam int TLB_DEPTH = 16;
	localparam int IDX_W     = (TLB_DEPTH > 1) ? $clog2(TLB_DEPTH) : 1;
	localparam int CNT_W     = $clog2(TLB_DEPTH + 1);
	localparam int KIND_W    = 2;
	localparam int PID_W     = 16;
	localparam int PAGE_W    = 16;
	localparam int FRAME_W   = 12;
	localparam int SLOT_W    = 4;
	localparam int STAMP_W   = 32;
	localparam int CFG_W     = 5;
	localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

	typedef enum logic [KIND_W-1:0] {
		KIND_FLUSH  = 2'd0,
		KIND_LOOKUP = 2'd1,
		KIND_INSERT = 2'd2,
		KIND_NOP    = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOOK,
		ST_SCAN
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic capture;
		logic exec;
		logic scan_init;
		logic scan_step;
		logic commit;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic need_scan;
		logic scan_done;
	} status_t;

endpackage

/* sv/tlu_ctrl.sv */
// controller for the tlb unit: sequences capture, search, victim scan and result
// depends on tlu_pkg
module tlu_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              out_ready,
	output logic              out_valid,
	input  tlu_pkg::status_t  status,
	output tlu_pkg::cmd_t     cmd
);

	tlu_pkg::state_t state_q, state_d;
	logic out_valid_q;
	logic out_ok;

	// result register free now or drained this cycle
	assign out_ok    = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			tlu_pkg::ST_IDLE: begin
				if (in_valid) state_d = tlu_pkg::ST_LOOK;
			end
			tlu_pkg::ST_LOOK: begin
				if (status.need_scan) state_d = tlu_pkg::ST_SCAN;
				else if (out_ok) state_d = tlu_pkg::ST_IDLE;
			end
			tlu_pkg::ST_SCAN: begin
				if (status.scan_done && out_ok) state_d = tlu_pkg::ST_IDLE;
			end
			default: state_d = tlu_pkg::ST_IDLE;
		endcase
	end

	// commands
	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			tlu_pkg::ST_IDLE: begin
				in_ready    = 1'b1;
				cmd.capture = in_valid;
			end
			tlu_pkg::ST_LOOK: begin
				if (status.need_scan) cmd.scan_init = 1'b1;
				else cmd.exec = out_ok;
			end
			tlu_pkg::ST_SCAN: begin
				if (!status.scan_done) cmd.scan_step = 1'b1;
				else cmd.commit = out_ok;
			end
			default: ;
		endcase
	end

	// state and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= tlu_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.exec || cmd.commit) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

endmodule

/* sv/tlu_dp.sv */
// datapath for the tlb unit: slot storage, parallel match, fill and lru scan
// depends on tlu_pkg
module tlu_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [tlu_pkg::CFG_W-1:0]     cfg_data,
	input  logic [tlu_pkg::KIND_W-1:0]    kind,
	input  logic [tlu_pkg::PID_W-1:0]     pid,
	input  logic [tlu_pkg::PAGE_W-1:0]    page,
	input  logic [tlu_pkg::FRAME_W-1:0]   frame,
	input  tlu_pkg::cmd_t                 cmd,
	output tlu_pkg::status_t              status,
	output logic                          hit,
	output logic [tlu_pkg::SLOT_W-1:0]    slot,
	output logic [tlu_pkg::FRAME_W-1:0]   frame_out
);

	localparam int D = tlu_pkg::TLB_DEPTH;

	logic [tlu_pkg::CFG_W-1:0]   entries_q;
	tlu_pkg::kind_t              kind_q;
	logic [tlu_pkg::PID_W-1:0]   pid_q;
	logic [tlu_pkg::PAGE_W-1:0]  page_q;
	logic [tlu_pkg::FRAME_W-1:0] frame_q;

	logic [D-1:0]                valid_q;
	logic [tlu_pkg::PID_W-1:0]   pid_arr_q   [D];
	logic [tlu_pkg::PAGE_W-1:0]  page_arr_q  [D];
	logic [tlu_pkg::FRAME_W-1:0] frame_arr_q [D];
	logic [tlu_pkg::STAMP_W-1:0] stamp_arr_q [D];
	logic [tlu_pkg::STAMP_W-1:0] use_clock_q;

	logic [tlu_pkg::IDX_W-1:0]   victim_q;
	logic [tlu_pkg::STAMP_W-1:0] best_q;
	logic [tlu_pkg::CNT_W-1:0]   scan_idx_q;

	logic                        hit_q;
	logic [tlu_pkg::SLOT_W-1:0]  slot_q;
	logic [tlu_pkg::FRAME_W-1:0] frame_out_q;

	logic [tlu_pkg::CNT_W-1:0]   n_act;
	logic [D-1:0]                active;
	logic [D-1:0]                hit_vec;
	logic [D-1:0]                empty_vec;
	logic                        any_hit;
	logic                        any_empty;
	logic [tlu_pkg::IDX_W-1:0]   hit_idx;
	logic [tlu_pkg::IDX_W-1:0]   empty_idx;
	logic                        fill_en;
	logic [tlu_pkg::IDX_W-1:0]   fill_idx;
	logic                        stamp_hit_en;
	logic                        do_flush;
	logic [tlu_pkg::STAMP_W-1:0] stamp_scan;
	logic                        out_hit_d;
	logic [tlu_pkg::SLOT_W-1:0]  out_slot_d;
	logic [tlu_pkg::FRAME_W-1:0] out_frame_d;

	// active slot count, saturated at the depth
	always_comb begin
		if (32'(entries_q) > 32'(D)) n_act = tlu_pkg::CNT_W'(D);
		else n_act = tlu_pkg::CNT_W'(entries_q);
		for (int i = 0; i < D; i++) begin
			active[i] = (32'(i) < 32'(n_act));
		end
	end

	// parallel tag compare and empty detect
	always_comb begin
		for (int i = 0; i < D; i++) begin
			hit_vec[i]   = valid_q[i] && active[i] &&
			               (pid_arr_q[i] == pid_q) && (page_arr_q[i] == page_q);
			empty_vec[i] = !valid_q[i] && active[i];
		end
	end

	// lowest set index of each vector
	always_comb begin
		hit_idx   = '0;
		empty_idx = '0;
		for (int i = D - 1; i >= 0; i--) begin
			if (hit_vec[i]) hit_idx = tlu_pkg::IDX_W'(i);
			if (empty_vec[i]) empty_idx = tlu_pkg::IDX_W'(i);
		end
		any_hit   = |hit_vec;
		any_empty = |empty_vec;
	end

	// update decisions
	assign do_flush     = cmd.exec && (kind_q == tlu_pkg::KIND_FLUSH);
	assign stamp_hit_en = cmd.exec && (kind_q == tlu_pkg::KIND_LOOKUP) && any_hit;
	assign fill_en      = (cmd.exec && (kind_q == tlu_pkg::KIND_INSERT) && !any_hit &&
	                       any_empty) || cmd.commit;
	assign fill_idx     = cmd.commit ? victim_q : empty_idx;

	// status toward the controller
	assign status.need_scan = (kind_q == tlu_pkg::KIND_INSERT) && !any_hit &&
	                          (n_act != '0) && !any_empty;
	assign status.scan_done = (scan_idx_q >= n_act);

	// stamp under the scan pointer
	assign stamp_scan = stamp_arr_q[scan_idx_q[tlu_pkg::IDX_W-1:0]];

	// result fields
	always_comb begin
		out_hit_d   = 1'b0;
		out_slot_d  = '0;
		out_frame_d = '0;
		if (cmd.commit) begin
			out_slot_d = tlu_pkg::SLOT_W'(victim_q);
		end else begin
			unique case (kind_q)
				tlu_pkg::KIND_LOOKUP: begin
					if (any_hit) begin
						out_hit_d   = 1'b1;
						out_slot_d  = tlu_pkg::SLOT_W'(hit_idx);
						out_frame_d = frame_arr_q[hit_idx];
					end
				end
				tlu_pkg::KIND_INSERT: begin
					if (any_hit) begin
						out_hit_d  = 1'b1;
						out_slot_d = tlu_pkg::SLOT_W'(hit_idx);
					end else if (any_empty) begin
						out_slot_d = tlu_pkg::SLOT_W'(empty_idx);
					end
				end
				default: ;
			endcase
		end
	end

	// config, valid bits and use counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entries_q   <= tlu_pkg::CFG_RESET;
			valid_q     <= '0;
			use_clock_q <= '0;
		end else begin
			if (cfg_we) entries_q <= cfg_data;
			if (do_flush) begin
				valid_q     <= '0;
				use_clock_q <= '0;
			end else if (fill_en) begin
				valid_q[fill_idx] <= 1'b1;
				use_clock_q       <= use_clock_q + tlu_pkg::STAMP_W'(1);
			end else if (stamp_hit_en) begin
				use_clock_q <= use_clock_q + tlu_pkg::STAMP_W'(1);
			end
		end
	end

	// item capture, slot contents, scan and result registers
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			kind_q  <= tlu_pkg::kind_t'(kind);
			pid_q   <= pid;
			page_q  <= page;
			frame_q <= frame;
		end
		if (fill_en) begin
			pid_arr_q[fill_idx]   <= pid_q;
			page_arr_q[fill_idx]  <= page_q;
			frame_arr_q[fill_idx] <= frame_q;
			stamp_arr_q[fill_idx] <= use_clock_q;
		end else if (stamp_hit_en) begin
			stamp_arr_q[hit_idx] <= use_clock_q;
		end
		// oldest stamp search, lowest index wins ties
		if (cmd.scan_init) begin
			victim_q   <= '0;
			best_q     <= stamp_arr_q[0];
			scan_idx_q <= tlu_pkg::CNT_W'(1);
		end else if (cmd.scan_step) begin
			if (stamp_scan < best_q) begin
				victim_q <= scan_idx_q[tlu_pkg::IDX_W-1:0];
				best_q   <= stamp_scan;
			end
			scan_idx_q <= scan_idx_q + tlu_pkg::CNT_W'(1);
		end
		if (cmd.exec || cmd.commit) begin
			hit_q       <= out_hit_d;
			slot_q      <= out_slot_d;
			frame_out_q <= out_frame_d;
		end
	end

	assign hit       = hit_q;
	assign slot      = slot_q;
	assign frame_out = frame_out_q;

endmodule

/* sv/tlb_lru_lookup_insert_unit.sv */
// Fully associative translation buffer keyed by (pid, page) with least recently
// used replacement. Each input beat is a flush, a lookup, an insert or a nop and
// gives one result beat. An accepted item goes to the search stage, where all
// active slots are compared in parallel, so flush, lookup, an insert of a present
// pair and an insert into an empty slot have their result registered from the
// search stage. An insert into a full buffer then scans the stamps of the active
// slots one per cycle to find the oldest, and its result is registered once the
// scan is done. A new item is accepted only in the idle state, after the last one
// has left the search or scan. A result that is not taken holds the search stage
// until it drains. The result register lets the next item be accepted while a
// result waits; the entry count register is written through the cfg channel,
// which is always ready.
// depends on tlu_pkg, tlu_ctrl, tlu_dp and the assertion macro header
`include "tlb_lru_lookup_insert_unit_macros.svh"

module tlb_lru_lookup_insert_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [tlu_pkg::CFG_W-1:0]     cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [tlu_pkg::KIND_W-1:0]    kind,
	input  logic [tlu_pkg::PID_W-1:0]     pid,
	input  logic [tlu_pkg::PAGE_W-1:0]    page,
	input  logic [tlu_pkg::FRAME_W-1:0]   frame,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          hit,
	output logic [tlu_pkg::SLOT_W-1:0]    slot,
	output logic [tlu_pkg::FRAME_W-1:0]   frame_out
);

	tlu_pkg::cmd_t    cmd;
	tlu_pkg::status_t status;

	// config writes are always accepted
	assign cfg_ready = 1'b1;

	// controller
	tlu_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.status    (status),
		.cmd       (cmd)
	);

	// datapath
	tlu_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_valid),
		.cfg_data  (cfg_data),
		.kind      (kind),
		.pid       (pid),
		.page      (page),
		.frame     (frame),
		.cmd       (cmd),
		.status    (status),
		.hit       (hit),
		.slot      (slot),
		.frame_out (frame_out)
	);

	// checks
	`TLU_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)
	`TLU_ASSERT_IMPLIES(a_no_result_overwrite, cmd.exec || cmd.commit, !out_valid || out_ready)
	`TLU_ASSERT_IMPLIES(a_result_from_item, $rose(out_valid), $past(!in_ready))

endmodule

/* dv/tb.sv */
`timescale 1ns / 1ps
// testbench for tlb_lru_lookup_insert_unit: flush, lookup, insert and nop traffic checked
// beat by beat against a behavioral copy of the translation buffer; needs tlu_pkg
module tb;
	import tlu_pkg::*;

	typedef struct packed {
		kind_t              kind;
		logic [PID_W-1:0]   pid;
		logic [PAGE_W-1:0]  page;
		logic [FRAME_W-1:0] frame;
	} tlb_req_t;

	typedef struct packed {
		logic               hit;
		logic [SLOT_W-1:0]  slot;
		logic [FRAME_W-1:0] frame;
	} xlat_res_t;

	logic                clk;
	logic                arst_n    = 1'b0;
	logic                cfg_valid = 1'b0;
	logic                cfg_ready;
	logic [CFG_W-1:0]    cfg_data  = '0;
	logic                in_valid  = 1'b0;
	logic                in_ready;
	logic [KIND_W-1:0]   kind      = '0;
	logic [PID_W-1:0]    pid       = '0;
	logic [PAGE_W-1:0]   page      = '0;
	logic [FRAME_W-1:0]  frame     = '0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	logic                hit;
	logic [SLOT_W-1:0]   slot;
	logic [FRAME_W-1:0]  frame_out;

	tlb_lru_lookup_insert_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.kind      (kind),
		.pid       (pid),
		.page      (page),
		.frame     (frame),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.hit       (hit),
		.slot      (slot),
		.frame_out (frame_out)
	);

	// shadow copy of the buffer contents and the entry count register
	logic                sh_valid [TLB_DEPTH];
	logic [PID_W-1:0]    sh_pid   [TLB_DEPTH];
	logic [PAGE_W-1:0]   sh_page  [TLB_DEPTH];
	logic [FRAME_W-1:0]  sh_frame [TLB_DEPTH];
	logic [STAMP_W-1:0]  sh_stamp [TLB_DEPTH];
	logic [STAMP_W-1:0]  sh_clock;
	logic [CFG_W-1:0]    sh_count;

	tlb_req_t  request_q[$];
	xlat_res_t xlat_results_q[$];
	tlb_req_t  cur_req;
	logic [31:0] pair_pool [40];

	int  pushed_count   = 0;
	int  accepted_count = 0;
	int  error_count    = 0;
	int  hit_count      = 0;
	int  evict_count    = 0;
	int  settings_seen  = 0;
	int  pool_span      = 20;
	int  tx_wait        = 0;
	int  rx_wait        = 0;
	bit  idle_on        = 1'b0;
	bit  stall_burst_req  = 1'b0;
	bit  stall_burst_done = 1'b0;
	logic in_took  = 1'b0;
	logic cfg_took = 1'b0;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// translation buffer behavior for one accepted beat, updates the shadow state
	function automatic xlat_res_t tlb_access(tlb_req_t r);
		xlat_res_t res;
		int n;
		int found;
		int victim;
		res = '0;
		n = (sh_count > TLB_DEPTH) ? TLB_DEPTH : int'(sh_count);
		found = -1;
		victim = -1;
		case (r.kind)
			KIND_FLUSH: begin
				for (int i = 0; i < TLB_DEPTH; i++) sh_valid[i] = 1'b0;
				sh_clock = '0;
			end
			KIND_LOOKUP, KIND_INSERT: begin
				for (int i = 0; i < n; i++)
					if (found < 0 && sh_valid[i] && sh_pid[i] == r.pid && sh_page[i] == r.page)
						found = i;
				if (r.kind == KIND_LOOKUP) begin
					if (found >= 0) begin
						sh_stamp[found] = sh_clock;
						sh_clock = sh_clock + 1;
						res = '{1'b1, SLOT_W'(found), sh_frame[found]};
						hit_count++;
					end
				end else if (found >= 0) begin
					res = '{1'b1, SLOT_W'(found), '0};
				end else if (n > 0) begin
					// lowest empty slot first, otherwise the oldest stamp
					for (int i = 0; i < n; i++)
						if (victim < 0 && !sh_valid[i]) victim = i;
					if (victim < 0) begin
						victim = 0;
						for (int i = 1; i < n; i++)
							if (sh_stamp[i] < sh_stamp[victim]) victim = i;
						evict_count++;
					end
					sh_valid[victim] = 1'b1;
					sh_pid[victim]   = r.pid;
					sh_page[victim]  = r.page;
					sh_frame[victim] = r.frame;
					sh_stamp[victim] = sh_clock;
					sh_clock = sh_clock + 1;
					res = '{1'b0, SLOT_W'(victim), '0};
				end
			end
			default: ;
		endcase
		return res;
	endfunction

	// idle length: mostly none, some short, a few long
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (!idle_on || r < 55) return 0;
		if (r < 90) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 10);
		return $urandom_range(20, 40);
	endfunction

	// mostly pairs from a small working set so lookups hit and inserts evict
	function automatic tlb_req_t rand_req();
		tlb_req_t r;
		int sel;
		sel = $urandom_range(0, 99);
		if (sel < 2)
			r.kind = KIND_FLUSH;
		else if (sel < 4)
			r.kind = KIND_NOP;
		else if (sel < 52)
			r.kind = KIND_LOOKUP;
		else
			r.kind = KIND_INSERT;
		if ($urandom_range(0, 9) < 8) begin
			{r.pid, r.page} = pair_pool[$urandom_range(0, pool_span - 1)];
		end else begin
			r.pid  = PID_W'($urandom);
			r.page = PAGE_W'($urandom);
		end
		r.frame = FRAME_W'($urandom);
		return r;
	endfunction

	task automatic send(tlb_req_t r);
		request_q.push_back(r);
		pushed_count++;
	endtask

	task automatic send_random(int count);
		for (int i = 0; i < count; i++) send(rand_req());
	endtask

	// every pushed beat accepted and every result beat returned
	task automatic wait_idle();
		do @(negedge clk);
		while (accepted_count != pushed_count || xlat_results_q.size() != 0);
	endtask

	task automatic write_entry_count(logic [CFG_W-1:0] v);
		wait_idle();
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do @(negedge clk);
		while (!cfg_took);
		cfg_valid <= 1'b0;
		settings_seen++;
		pool_span = ((v > TLB_DEPTH) ? TLB_DEPTH : int'(v)) + 4;
	endtask

	// request driver, one beat held until taken
	always @(negedge clk) begin
		if (arst_n && (!in_valid || in_took)) begin
			if (tx_wait > 0) begin
				in_valid <= 1'b0;
				tx_wait--;
			end else if (request_q.size() > 0) begin
				cur_req = request_q.pop_front();
				kind     <= cur_req.kind;
				pid      <= cur_req.pid;
				page     <= cur_req.page;
				frame    <= cur_req.frame;
				in_valid <= 1'b1;
				tx_wait = pick_gap();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// result ready with random stalls and one long hold on request
	always @(negedge clk) begin
		if (stall_burst_req && !stall_burst_done) begin
			rx_wait = 200;
			stall_burst_done = 1'b1;
		end
		if (rx_wait > 0) begin
			out_ready <= 1'b0;
			rx_wait--;
		end else begin
			out_ready <= 1'b1;
			rx_wait = pick_gap();
		end
	end

	// monitor: accepted requests and config writes feed the shadow, results are checked
	always @(posedge clk) begin
		xlat_res_t want;
		if (arst_n) begin
			in_took  <= in_valid && in_ready;
			cfg_took <= cfg_valid && cfg_ready;
			if (cfg_valid && cfg_ready) sh_count = cfg_data;
			if (in_valid && in_ready) begin
				xlat_results_q.push_back(tlb_access('{kind_t'(kind), pid, page, frame}));
				accepted_count++;
			end
			if (out_valid && out_ready) begin
				if (xlat_results_q.size() == 0) begin
					$error("result beat with nothing outstanding");
					error_count++;
				end else begin
					want = xlat_results_q.pop_front();
					if (hit !== want.hit) begin
						$error("hit: expected %0d actual %0d", want.hit, hit);
						error_count++;
					end
					if (slot !== want.slot) begin
						$error("slot: expected %0d actual %0d", want.slot, slot);
						error_count++;
					end
					if (frame_out !== want.frame) begin
						$error("frame_out: expected %0h actual %0h", want.frame, frame_out);
						error_count++;
					end
				end
			end
		end
	end

	// stimulus and end of run
	initial begin
		logic [CFG_W-1:0] plan [12];
		sh_count = CFG_RESET;
		sh_clock = '0;
		for (int i = 0; i < TLB_DEPTH; i++) begin
			sh_valid[i] = 1'b0;
			sh_pid[i]   = '0;
			sh_page[i]  = '0;
			sh_frame[i] = '0;
			sh_stamp[i] = '0;
		end
		for (int i = 0; i < 40; i++) pair_pool[i] = $urandom;
		pair_pool[0] = '0;
		pair_pool[1] = '1;
		plan = '{5'd16, 5'd4, 5'd16, 5'd1, 5'd0, 5'd31, 5'd17, 5'd8, 5'd2,
			CFG_W'($urandom_range(0, 31)), 5'd15, 5'd16};

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: empty miss, extreme fields, present pair, fill, eviction, flush
		idle_on = 1'b1;
		send('{KIND_LOOKUP, 16'h0000, 16'h0000, 12'h000});
		send('{KIND_INSERT, 16'h0000, 16'h0000, 12'h000});
		send('{KIND_INSERT, 16'hFFFF, 16'hFFFF, 12'hFFF});
		send('{KIND_LOOKUP, 16'hFFFF, 16'hFFFF, 12'h000});
		send('{KIND_LOOKUP, 16'h0000, 16'h0000, 12'hFFF});
		send('{KIND_INSERT, 16'h0000, 16'h0000, 12'h123});
		send('{KIND_LOOKUP, 16'h0000, 16'hFFFF, 12'h000});
		send('{KIND_NOP,    16'hFFFF, 16'hFFFF, 12'hFFF});
		for (int i = 2; i < TLB_DEPTH; i++)
			send('{KIND_INSERT, PID_W'(i), PAGE_W'(i), FRAME_W'(i * 37)});
		send('{KIND_INSERT, 16'h5A5A, 16'hA5A5, 12'hABC});
		send('{KIND_FLUSH,  16'h1234, 16'h5678, 12'h9AB});
		send('{KIND_LOOKUP, 16'h0000, 16'h0000, 12'h000});

		// random phases over several entry counts, extremes included
		for (int p = 0; p < 12; p++) begin
			write_entry_count(plan[p]);
			idle_on = (p % 4) != 3;
			if (p == 2) begin
				// receiver holds off while the sender keeps offering
				idle_on = 1'b0;
				stall_burst_req = 1'b1;
				send_random(105);
			end else if (p == 7) begin
				// sender waits for the block to drain mid phase
				send_random(50);
				wait_idle();
				send_random(55);
			end else begin
				send_random(105);
			end
		end

		wait_idle();
		repeat (30) @(negedge clk);
		$display("ran %0d beats over %0d entry-count settings (0, 1, full, above depth)",
			accepted_count, settings_seen);
		$display("saw %0d lookup hits and %0d replacements of the oldest entry",
			hit_count, evict_count);
		if (error_count == 0 && xlat_results_q.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// watchdog
	initial begin
		#5_000_000;
		$display("run did not finish in time");
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
